FILE: rtl/core/lrg_pkg.sv
// Shared types, widths and a helper function for the line raster generator.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package lrg_pkg;

   localparam int CoordBits = 10;
   localparam int ErrBits   = CoordBits + 2;
   localparam int StepBits  = CoordBits + 1;
   localparam int ColorBits = 16;

   typedef logic [CoordBits-1:0] coord_type;
   typedef logic [ErrBits-1:0]   err_type;
   typedef logic [StepBits-1:0]  step_type;
   typedef logic [ColorBits-1:0] color_type;
   typedef logic [1:0]           dir_type;

   // Step direction codes, two's complement in two bits.
   localparam dir_type DIR_NONE = 2'b00;
   localparam dir_type DIR_POS  = 2'b01;
   localparam dir_type DIR_NEG  = 2'b11;

   typedef enum logic {
      ACTION_START = 1'b0,
      ACTION_STEP  = 1'b1
   } action_type;

   // Line parameters worked out from the two endpoints of a start request.
   typedef struct packed {
      coord_type abs_dx;
      coord_type abs_dy;
      dir_type   dir_x;
      dir_type   dir_y;
      coord_type major_len;
   } setup_type;

   // One emitted pixel, as handed from the stepping core to the output stage.
   typedef struct packed {
      logic      valid;
      coord_type x;
      coord_type y;
      color_type color;
      logic      last;
   } pixel_type;

   function automatic coord_type advance(coord_type pos, dir_type dir);
      coord_type result;
      case (dir)
         DIR_POS: result = pos + CoordBits'(1);
         DIR_NEG: result = pos - CoordBits'(1);
         default: result = pos;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/line_raster_generator_unit.sv
// Line raster generator: a start request loads a line; a step while busy emits a pixel.
// A pixel appears on rsp_valid in the cycle after its step request is accepted.
// Throughput: one request per clock unless rsp_ready stalls the output; the stepping
// core updates its errors each step; the single output register refills as it drains.
// Reset (synchronous, active high) leaves the block idle with no response pending.
// Depends on lrg_pkg, lrg_line_setup and lrg_step_core.
`default_nettype none

module line_raster_generator_unit (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [0:0]  req_action,
   input  wire  [9:0]  req_x_start,
   input  wire  [9:0]  req_y_start,
   input  wire  [9:0]  req_x_end,
   input  wire  [9:0]  req_y_end,
   input  wire  [15:0] req_pen_color,

   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [9:0]  rsp_pixel_x,
   output logic [9:0]  rsp_pixel_y,
   output logic [15:0] rsp_pixel_color,
   output logic [0:0]  rsp_last_pixel
);

   logic               req_fire;
   logic               load;
   logic               step;
   lrg_pkg::setup_type setup;
   lrg_pkg::pixel_type pixel;

   logic               rsp_valid_ff, rsp_valid_in;
   lrg_pkg::coord_type rsp_x_ff, rsp_x_in;
   lrg_pkg::coord_type rsp_y_ff, rsp_y_in;
   lrg_pkg::color_type rsp_color_ff, rsp_color_in;
   logic               rsp_last_ff, rsp_last_in;

   // A request is taken whenever the output register is empty or is being
   // drained this cycle, so a waiting pixel never blocks the next request
   // from entering once the consumer takes it.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign load      = req_fire && (req_action == lrg_pkg::ACTION_START);
   assign step      = req_fire && (req_action == lrg_pkg::ACTION_STEP);

   lrg_line_setup u_setup (
      .x_start (req_x_start),
      .y_start (req_y_start),
      .x_end   (req_x_end),
      .y_end   (req_y_end),
      .setup   (setup)
   );

   lrg_step_core u_core (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .step    (step),
      .setup   (setup),
      .x_start (req_x_start),
      .y_start (req_y_start),
      .color   (req_pen_color),
      .pixel   (pixel)
   );

   // Output register. A step while idle produces nothing, and a start request
   // never produces a response, so only a valid pixel refills the register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      if (pixel.valid) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = pixel.x;
         rsp_y_in     = pixel.y;
         rsp_color_in = pixel.color;
         rsp_last_in  = pixel.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last_pixel  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lrg_line_setup.sv
// Endpoint decode for a start request: absolute deltas, directions, major length.
// Depends on lrg_pkg.
`default_nettype none

module lrg_line_setup (
   input  wire lrg_pkg::coord_type x_start,
   input  wire lrg_pkg::coord_type y_start,
   input  wire lrg_pkg::coord_type x_end,
   input  wire lrg_pkg::coord_type y_end,
   output lrg_pkg::setup_type      setup
);

   always_comb begin
      setup = '0;
      if (x_end > x_start) begin
         setup.abs_dx = x_end - x_start;
         setup.dir_x  = lrg_pkg::DIR_POS;
      end else if (x_end == x_start) begin
         setup.abs_dx = '0;
         setup.dir_x  = lrg_pkg::DIR_NONE;
      end else begin
         setup.abs_dx = x_start - x_end;
         setup.dir_x  = lrg_pkg::DIR_NEG;
      end

      if (y_end > y_start) begin
         setup.abs_dy = y_end - y_start;
         setup.dir_y  = lrg_pkg::DIR_POS;
      end else if (y_end == y_start) begin
         setup.abs_dy = '0;
         setup.dir_y  = lrg_pkg::DIR_NONE;
      end else begin
         setup.abs_dy = y_start - y_end;
         setup.dir_y  = lrg_pkg::DIR_NEG;
      end

      setup.major_len = (setup.abs_dx > setup.abs_dy) ? setup.abs_dx : setup.abs_dy;
   end

endmodule

`default_nettype wire

FILE: rtl/core/lrg_step_core.sv
// Line state registers and the per-pixel error-accumulation step.
// Depends on lrg_pkg.
`default_nettype none

module lrg_step_core (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     load,
   input  wire                     step,
   input  wire lrg_pkg::setup_type setup,
   input  wire lrg_pkg::coord_type x_start,
   input  wire lrg_pkg::coord_type y_start,
   input  wire lrg_pkg::color_type color,
   output lrg_pkg::pixel_type      pixel
);

   lrg_pkg::coord_type cur_x_ff, cur_x_in;
   lrg_pkg::coord_type cur_y_ff, cur_y_in;
   lrg_pkg::err_type   err_x_ff, err_x_in;
   lrg_pkg::err_type   err_y_ff, err_y_in;
   lrg_pkg::setup_type line_ff, line_in;
   lrg_pkg::step_type  steps_left_ff, steps_left_in;
   logic               busy_ff, busy_in;
   lrg_pkg::color_type color_ff, color_in;

   lrg_pkg::err_type   err_x_sum, err_y_sum, major_ext;
   lrg_pkg::step_type  steps_dec;

   assign major_ext = lrg_pkg::ErrBits'(line_ff.major_len);
   assign err_x_sum = err_x_ff + lrg_pkg::ErrBits'(line_ff.abs_dx);
   assign err_y_sum = err_y_ff + lrg_pkg::ErrBits'(line_ff.abs_dy);
   assign steps_dec = steps_left_ff - lrg_pkg::StepBits'(1);

   // The pixel shown is the position before this step's advance.
   always_comb begin
      pixel.valid = step && busy_ff;
      pixel.x     = cur_x_ff;
      pixel.y     = cur_y_ff;
      pixel.color = color_ff;
      pixel.last  = (steps_left_ff == lrg_pkg::StepBits'(1));
   end

   always_comb begin
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      err_x_in      = err_x_ff;
      err_y_in      = err_y_ff;
      line_in       = line_ff;
      steps_left_in = steps_left_ff;
      busy_in       = busy_ff;
      color_in      = color_ff;

      if (load) begin
         cur_x_in      = x_start;
         cur_y_in      = y_start;
         err_x_in      = '0;
         err_y_in      = '0;
         line_in       = setup;
         steps_left_in = lrg_pkg::StepBits'(setup.major_len) + lrg_pkg::StepBits'(2);
         busy_in       = 1'b1;
         color_in      = color;
      end else if (step && busy_ff) begin
         err_x_in = err_x_sum;
         if (err_x_sum > major_ext) begin
            err_x_in = err_x_sum - major_ext;
            cur_x_in = lrg_pkg::advance(cur_x_ff, line_ff.dir_x);
         end
         err_y_in = err_y_sum;
         if (err_y_sum > major_ext) begin
            err_y_in = err_y_sum - major_ext;
            cur_y_in = lrg_pkg::advance(cur_y_ff, line_ff.dir_y);
         end
         steps_left_in = steps_dec;
         busy_in       = (steps_dec != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         steps_left_ff <= '0;
      end else begin
         busy_ff       <= busy_in;
         steps_left_ff <= steps_left_in;
      end
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      err_x_ff <= err_x_in;
      err_y_ff <= err_y_in;
      line_ff  <= line_in;
      color_ff <= color_in;
   end

endmodule

`default_nettype wire
